[rtl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared constants, types and helpers for the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int BAND_LOG2  = 13;
  localparam int BAND       = 1 << BAND_LOG2;
  localparam int KEY_W      = BAND_LOG2;
  localparam int LEAF_IDX_W = BAND_LOG2 - 6;
  localparam int LEAF_WORDS = 1 << LEAF_IDX_W;
  localparam int MID_LOG2   = BAND_LOG2 - 12;
  localparam int MID_WORDS  = 1 << MID_LOG2;
  localparam int SLOT_LOG2  = 16;
  localparam int SLOT_COUNT = 1 << SLOT_LOG2;
  localparam int PTR_W      = SLOT_LOG2 + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [KEY_W:0]   bkey_t;

  localparam ptr_t  SLOT_NONE = ptr_t'(SLOT_COUNT);
  localparam bkey_t KEY_EMPTY = bkey_t'(BAND);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHECK = 13'b0000000000010,
    S_MATCH = 13'b0000000000100,
    S_HEAD  = 13'b0000000001000,
    S_FILL  = 13'b0000000010000,
    S_UNM1  = 13'b0000000100000,
    S_UNM2  = 13'b0000001000000,
    S_SCAN  = 13'b0000010000000,
    S_SCAN2 = 13'b0000100000000,
    S_REST  = 13'b0001000000000,
    S_REST2 = 13'b0010000000000,
    S_REST3 = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic match;
    logic head;
    logic fill;
    logic unm_rd;
    logic unm_upd;
    logic scan;
    logic scan_rd;
    logic rest;
    logic rest_wr;
    logic link_tail;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic match_go;
    logic level_empty;
    logic fill_cont;
    logic v_nz;
    logic top_empty;
    logic rest_need;
    logic full;
    logic occupied;
    logic out_free;
  } stat_t;

  function automatic logic [5:0] lz64(input logic [63:0] v);
    logic [5:0] r;
    r = 6'd63;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [MID_LOG2-1:0] lztop(input logic [MID_WORDS-1:0] v);
    logic [MID_LOG2-1:0] r;
    r = MID_LOG2'(MID_WORDS - 1);
    for (int i = MID_WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = MID_LOG2'(i);
    end
    return r;
  endfunction

endpackage

[rtl/lobm_ctrl.sv]
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer for band check, matching walk, level unmark, rest and report.
// ----------------------------------------------------------------------------
module lobm_ctrl import lobm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = st.reject ? S_DONE : S_MATCH;
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = st.match_go ? S_HEAD : S_REST;
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (st.level_empty)    state_next = S_UNM1;
        else if (st.fill_cont) state_next = S_FILL;
        else                   state_next = S_DONE;
      end
      S_UNM1: begin
        cmd.unm_rd = 1'b1;
        state_next = S_UNM2;
      end
      S_UNM2: begin
        cmd.unm_upd = 1'b1;
        state_next  = st.v_nz ? S_MATCH : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = st.top_empty ? S_MATCH : S_SCAN2;
      end
      S_SCAN2: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_MATCH;
      end
      S_REST: begin
        cmd.rest   = 1'b1;
        state_next = (!st.rest_need || st.full) ? S_DONE : S_REST2;
      end
      S_REST2: begin
        cmd.rest_wr = 1'b1;
        state_next  = st.occupied ? S_REST3 : S_DONE;
      end
      S_REST3: begin
        cmd.link_tail = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/lobm_dp.sv]
// ----------------------------------------------------------------------------
// lobm_dp
// Book state, slot store, level queues, occupancy bitmaps and report register.
// ----------------------------------------------------------------------------
module lobm_dp import lobm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        side,
  input  logic [31:0] limit_price,
  input  logic [31:0] quantity,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  status,
  output logic [31:0] filled_qty,
  output logic [16:0] fill_count,
  output logic [31:0] rested_qty,
  output logic [31:0] bid_price,
  output logic [31:0] ask_price,
  output logic [63:0] trades_so_far,
  output logic [63:0] volume_so_far,
  output logic [16:0] orders_resting,
  output logic [63:0] orders_rejected
);

  localparam int LVL_W = KEY_W + 1;
  localparam int LI_W  = LEAF_IDX_W + 1;
  localparam int MI_W  = MID_LOG2 + 1;

  logic [31:0] slot_qty  [SLOT_COUNT];
  ptr_t        slot_link [SLOT_COUNT];
  ptr_t        lvl_first [2*BAND];
  ptr_t        lvl_last  [2*BAND];
  logic [63:0] leaf      [2*LEAF_WORDS];
  logic [2*LEAF_WORDS-1:0] leaf_vld;
  logic [63:0] mid [2*MID_WORDS];
  logic [MID_WORDS-1:0] top [2];

  logic        side_q;
  logic [31:0] price_q, qty_q, base;
  key_t        ckey, rkey, cur_key;
  bkey_t       best [2];
  ptr_t        head, free_ptr, tail_q;
  logic [SLOT_LOG2:0]   wm;
  logic [SLOT_LOG2-1:0] idx_q;
  logic [LEAF_IDX_W-1:0] scan_i1;
  logic [16:0] resting, fills;
  logic [63:0] trades, volume, rejects;
  logic [1:0]  st_q;
  logic [31:0] filled, rested;

  logic [31:0] sq_rd;
  ptr_t        link_rd, lf_rd, ll_rd;
  logic [63:0] leaf_rd;
  logic        leaf_vld_q;

  logic [31:0] diff, new_base, diff2;
  logic        in_band, book_empty;
  key_t        tick;
  bkey_t       best_con;
  logic [31:0] m, qty_new;
  logic        emptied;
  logic [SLOT_LOG2-1:0] slot_raddr, alloc_idx;
  logic [LI_W-1:0]  leaf_raddr;
  logic [63:0] leaf_word, v, w;
  logic [MI_W-1:0] unm_mi, scan_mi;
  logic [MID_LOG2-1:0] i2;
  logic [LEAF_IDX_W-1:0] i1;
  logic        from_stack;
  logic [31:0] bb_val, ba_val;

  always_comb begin
    diff       = price_q - base;
    in_band    = (price_q >= base) && (diff[31:KEY_W] == '0);
    book_empty = (resting == '0) && (top[0] == '0) && (top[1] == '0);
    new_base   = (price_q >= 32'(BAND / 2)) ? price_q - 32'(BAND / 2) : 32'd0;
    diff2      = price_q - new_base;
    tick       = in_band ? diff[KEY_W-1:0] : diff2[KEY_W-1:0];
    best_con   = best[side_q];
    m          = (sq_rd < qty_q) ? sq_rd : qty_q;
    qty_new    = qty_q - m;
    emptied    = (sq_rd == m);
    leaf_word  = leaf_rd & {64{leaf_vld_q}};
    v          = leaf_word & ~(64'd1 << cur_key[5:0]);
    unm_mi     = {side_q, cur_key[KEY_W-1 -: MID_LOG2]};
    w          = mid[unm_mi] & ~(64'd1 << cur_key[11:6]);
    i2         = lztop(top[side_q]);
    scan_mi    = {side_q, i2};
    i1         = {i2, lz64(mid[scan_mi])};
    from_stack = (free_ptr != SLOT_NONE);
    alloc_idx  = from_stack ? free_ptr[SLOT_LOG2-1:0] : wm[SLOT_LOG2-1:0];
    bb_val     = best[1][KEY_W] ? 32'd0 : base + 32'(best[1][KEY_W-1:0] ^ {KEY_W{1'b1}});
    ba_val     = best[0][KEY_W] ? 32'd0 : base + 32'(best[0][KEY_W-1:0]);

    if (cmd.head)      slot_raddr = lf_rd[SLOT_LOG2-1:0];
    else if (cmd.fill) slot_raddr = link_rd[SLOT_LOG2-1:0];
    else               slot_raddr = free_ptr[SLOT_LOG2-1:0];

    if (cmd.unm_rd)    leaf_raddr = {side_q, cur_key[KEY_W-1:6]};
    else if (cmd.scan) leaf_raddr = {side_q, i1};
    else               leaf_raddr = {~side_q, rkey[KEY_W-1:6]};

    st.reject      = !in_band && !book_empty;
    st.match_go    = (qty_q != '0) && !best_con[KEY_W] && (best_con[KEY_W-1:0] <= ckey);
    st.level_empty = emptied && (link_rd == SLOT_NONE);
    st.fill_cont   = (qty_new != '0) && emptied && (link_rd != SLOT_NONE);
    st.v_nz        = (v != '0);
    st.top_empty   = (top[side_q] == '0);
    st.rest_need   = (qty_q != '0);
    st.full        = !from_stack && (wm == (SLOT_LOG2+1)'(SLOT_COUNT));
    st.occupied    = leaf_word[rkey[5:0]];
    st.out_free    = !out_valid || out_ready;
  end

  // memory reads
  always_ff @(posedge clk) begin
    sq_rd      <= slot_qty[slot_raddr];
    link_rd    <= slot_link[slot_raddr];
    lf_rd      <= lvl_first[LVL_W'({side_q, best_con[KEY_W-1:0]})];
    ll_rd      <= lvl_last[LVL_W'({~side_q, rkey})];
    leaf_rd    <= leaf[leaf_raddr];
    leaf_vld_q <= leaf_vld[leaf_raddr];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      slot_qty[head[SLOT_LOG2-1:0]] <= sq_rd - m;
      lvl_first[LVL_W'({side_q, cur_key})] <= emptied ? link_rd : head;
    end else if (cmd.rest_wr) begin
      slot_qty[alloc_idx] <= qty_q;
      if (!st.occupied) lvl_first[LVL_W'({~side_q, rkey})] <= ptr_t'(alloc_idx);
    end
    if (cmd.fill && emptied)  slot_link[head[SLOT_LOG2-1:0]] <= free_ptr;
    else if (cmd.rest_wr)     slot_link[alloc_idx] <= SLOT_NONE;
    else if (cmd.link_tail)   slot_link[tail_q[SLOT_LOG2-1:0]] <= ptr_t'(idx_q);
    if (cmd.rest_wr) lvl_last[LVL_W'({~side_q, rkey})] <= ptr_t'(alloc_idx);
    if (cmd.unm_upd) leaf[{side_q, cur_key[KEY_W-1:6]}] <= v;
    else if (cmd.rest_wr && !st.occupied)
      leaf[{~side_q, rkey[KEY_W-1:6]}] <= leaf_word | (64'd1 << rkey[5:0]);
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      side_q  <= side;
      price_q <= limit_price;
      qty_q   <= quantity;
    end
    if (cmd.check) begin
      ckey <= tick ^ {KEY_W{side_q}};
      rkey <= tick ^ {KEY_W{~side_q}};
    end
    if (cmd.match) cur_key <= best_con[KEY_W-1:0];
    if (cmd.head)  head <= lf_rd;
    if (cmd.fill) begin
      qty_q <= qty_new;
      if (emptied) head <= link_rd;
    end
    if (cmd.scan)    scan_i1 <= i1;
    if (cmd.rest_wr) begin
      tail_q <= ll_rd;
      idx_q  <= alloc_idx;
    end
    if (cmd.finish) begin
      status          <= st_q;
      filled_qty      <= filled;
      fill_count      <= fills;
      rested_qty      <= rested;
      bid_price       <= bb_val;
      ask_price       <= ba_val;
      trades_so_far   <= trades;
      volume_so_far   <= volume;
      orders_resting  <= resting;
      orders_rejected <= rejects;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      best[0]   <= KEY_EMPTY;
      best[1]   <= KEY_EMPTY;
      top[0]    <= '0;
      top[1]    <= '0;
      for (int i = 0; i < 2*MID_WORDS; i++) mid[i] <= '0;
      leaf_vld  <= '0;
      free_ptr  <= SLOT_NONE;
      wm        <= '0;
      resting   <= '0;
      trades    <= '0;
      volume    <= '0;
      rejects   <= '0;
      st_q      <= ST_OK;
      filled    <= '0;
      fills     <= '0;
      rested    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        st_q   <= ST_OK;
        filled <= '0;
        fills  <= '0;
        rested <= '0;
      end
      if (cmd.check && !in_band) begin
        if (book_empty) base <= new_base;
        else begin
          rejects <= rejects + 64'd1;
          st_q    <= ST_REJECT;
        end
      end
      if (cmd.fill) begin
        trades <= trades + 64'd1;
        volume <= volume + 64'(m);
        fills  <= fills + 17'd1;
        filled <= filled + m;
        if (emptied) begin
          free_ptr <= head;
          resting  <= resting - 17'd1;
        end
      end
      if (cmd.unm_upd) begin
        if (v != '0) best[side_q] <= {1'b0, cur_key[KEY_W-1:6], lz64(v)};
        else begin
          mid[unm_mi] <= w;
          if (w == '0) top[side_q][cur_key[KEY_W-1 -: MID_LOG2]] <= 1'b0;
        end
      end
      if (cmd.scan && (top[side_q] == '0)) best[side_q] <= KEY_EMPTY;
      if (cmd.scan_rd) best[side_q] <= {1'b0, scan_i1, lz64(leaf_word)};
      if (cmd.rest && st.rest_need && st.full) st_q <= ST_FULL;
      if (cmd.rest_wr) begin
        if (from_stack) free_ptr <= link_rd;
        else            wm <= wm + (SLOT_LOG2+1)'(1);
        resting <= resting + 17'd1;
        rested  <= qty_q;
        if (!st.occupied) begin
          leaf_vld[{~side_q, rkey[KEY_W-1:6]}] <= 1'b1;
          mid[{~side_q, rkey[KEY_W-1 -: MID_LOG2]}][rkey[11:6]] <= 1'b1;
          top[~side_q][rkey[KEY_W-1 -: MID_LOG2]] <= 1'b1;
          if ({1'b0, rkey} < best[~side_q]) best[~side_q] <= {1'b0, rkey};
        end
      end
      if (cmd.finish)     out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

[rtl/limit_order_book_matcher_top.sv]
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Price-time priority limit order book: one order request in, one report out.
// ----------------------------------------------------------------------------
// Orders are taken one at a time; in_ready is high only while idle. After the
// request the band is checked in S_CHECK, and a rejected order goes straight
// to its report. Otherwise each look at the opposite side's best level is an
// S_MATCH step, followed on a match by opening that level in S_HEAD and by one
// trade against its queue per S_FILL step; a level that empties passes through
// bitmap update and best-tick rescan (S_UNM1, S_UNM2, then S_SCAN and S_SCAN2
// if needed) before the next look. When the walk stops short of exhausting the
// order, S_REST tests for a free slot and a remainder rests in S_REST2, with
// S_REST3 linking it behind an occupied level's tail. The report is loaded
// in S_DONE, which waits while an earlier report is still unread. The slot
// store and level queues are single-port-write memories; the walk is bounded by
// their one read and one write per cycle. No clearing pass is needed after reset.
module limit_order_book_matcher_top import lobm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        side,
  input  logic [31:0] limit_price,
  input  logic [31:0] quantity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] filled_qty,
  output logic [16:0] fill_count,
  output logic [31:0] rested_qty,
  output logic [31:0] bid_price,
  output logic [31:0] ask_price,
  output logic [63:0] trades_so_far,
  output logic [63:0] volume_so_far,
  output logic [16:0] orders_resting,
  output logic [63:0] orders_rejected
);

  cmd_t  cmd;
  stat_t st;

  lobm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lobm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .side            (side),
    .limit_price     (limit_price),
    .quantity        (quantity),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .status          (status),
    .filled_qty      (filled_qty),
    .fill_count      (fill_count),
    .rested_qty      (rested_qty),
    .bid_price       (bid_price),
    .ask_price       (ask_price),
    .trades_so_far   (trades_so_far),
    .volume_so_far   (volume_so_far),
    .orders_resting  (orders_resting),
    .orders_rejected (orders_rejected)
  );

endmodule

[rtl/lobm_checker.sv]
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on the matcher's reports and handshake.
// ----------------------------------------------------------------------------
module lobm_checker import lobm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] filled_qty,
  input logic [16:0] fill_count,
  input logic [31:0] rested_qty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(filled_qty))
    else $error("report changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_REJECT) |->
      (filled_qty == '0) && (fill_count == '0) && (rested_qty == '0))
    else $error("rejected order traded or rested");

  a_full_no_rest: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (rested_qty == '0))
    else $error("dropped remainder reported as rested");

  a_fill_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((fill_count == '0) == (filled_qty == '0)))
    else $error("fill count and filled quantity disagree");

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .filled_qty (filled_qty),
  .fill_count (fill_count),
  .rested_qty (rested_qty)
);

[tb/tb_limit_order_book_matcher_top.sv]
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_top
// Self-checking bench for the limit order book matcher. A local book model
// (per-tick FIFO queues keyed as in the block: asks direct, bids inverted)
// predicts each report; directed, random, back-pressure and drain phases.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher_top;
  import lobm_pkg::*;

  localparam int unsigned KMASK = BAND - 1;
  localparam int          LIMIT = 3000000;

  logic        clk, rst;
  logic        in_valid, in_ready, side;
  logic [31:0] limit_price, quantity;
  logic        out_valid, out_ready;
  logic [1:0]  status;
  logic [31:0] filled_qty, rested_qty, bid_price, ask_price;
  logic [16:0] fill_count, orders_resting;
  logic [63:0] trades_so_far, volume_so_far, orders_rejected;

  limit_order_book_matcher_top dut (.*);

  typedef struct {
    logic [1:0]  status;
    logic [31:0] filled, rested, bid, ask;
    logic [16:0] fills, resting;
    logic [63:0] trades, volume, rejects;
  } order_report_t;

  typedef bit [31:0] qty_list_t[$];

  order_report_t exp_reports[$];
  qty_list_t     levels[2][int];
  bit [31:0]     band_base;
  int unsigned   resting_cnt;
  bit [63:0]     trade_tot, volume_tot, reject_tot;
  int            errors;
  int            hold_cycles;
  longint        cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic bit [31:0] best_price(int h);
    int k;
    if (levels[h].num() == 0) return 0;
    void'(levels[h].first(k));
    return band_base + ((h == 1) ? (k ^ KMASK) : k);
  endfunction

  function automatic order_report_t book_order(bit sd, bit [31:0] price, bit [31:0] qty);
    order_report_t r;
    bit            in_band;
    int            con, rs, ckey, rkey, k;
    bit [31:0]     tick, m;
    r = '{default: 0};
    in_band = price >= band_base && (price - band_base) < BAND;
    if (!in_band) begin
      if (resting_cnt == 0) begin
        band_base = (price >= BAND / 2) ? price - BAND / 2 : 0;
        in_band = price >= band_base && (price - band_base) < BAND;
      end
      if (!in_band) begin
        reject_tot++;
        r.status = ST_REJECT;
      end
    end
    if (in_band) begin
      tick = price - band_base;
      con  = sd;
      rs   = !sd;
      ckey = tick ^ (con ? KMASK : 0);
      rkey = tick ^ (rs ? KMASK : 0);
      while (qty > 0 && levels[con].num() > 0) begin
        void'(levels[con].first(k));
        if (k > ckey) break;
        while (qty > 0 && levels[con][k].size() > 0) begin
          m = (levels[con][k][0] < qty) ? levels[con][k][0] : qty;
          trade_tot++;
          volume_tot += m;
          r.fills++;
          r.filled += m;
          qty -= m;
          levels[con][k][0] -= m;
          if (levels[con][k][0] == 0) begin
            void'(levels[con][k].pop_front());
            resting_cnt--;
          end
        end
        if (levels[con][k].size() == 0) levels[con].delete(k);
      end
      if (qty > 0) begin
        if (resting_cnt >= SLOT_COUNT) begin
          r.status = ST_FULL;
        end else begin
          levels[rs][rkey].push_back(qty);
          resting_cnt++;
          r.rested = qty;
        end
      end
    end
    r.bid     = best_price(1);
    r.ask     = best_price(0);
    r.trades  = trade_tot;
    r.volume  = volume_tot;
    r.resting = 17'(resting_cnt);
    r.rejects = reject_tot;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s mismatch: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  // receiver side: random stalls, plus one long hold when asked
  initial begin
    int stall;
    order_report_t e;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (exp_reports.size() == 0) begin
        report_mismatch("unexpected report", 64'd1, 64'd0);
      end else begin
        e = exp_reports.pop_front();
        if (status !== e.status) report_mismatch("status", 64'(status), 64'(e.status));
        if (filled_qty !== e.filled)
          report_mismatch("filled_qty", 64'(filled_qty), 64'(e.filled));
        if (fill_count !== e.fills)
          report_mismatch("fill_count", 64'(fill_count), 64'(e.fills));
        if (rested_qty !== e.rested)
          report_mismatch("rested_qty", 64'(rested_qty), 64'(e.rested));
        if (bid_price !== e.bid) report_mismatch("bid_price", 64'(bid_price), 64'(e.bid));
        if (ask_price !== e.ask) report_mismatch("ask_price", 64'(ask_price), 64'(e.ask));
        if (trades_so_far !== e.trades) report_mismatch("trades", trades_so_far, e.trades);
        if (volume_so_far !== e.volume) report_mismatch("volume", volume_so_far, e.volume);
        if (orders_resting !== e.resting)
          report_mismatch("orders_resting", 64'(orders_resting), 64'(e.resting));
        if (orders_rejected !== e.rejects)
          report_mismatch("orders_rejected", orders_rejected, e.rejects);
      end
    end
  end

  task automatic send_order(bit sd, bit [31:0] price, bit [31:0] qty, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    side        <= sd;
    limit_price <= price;
    quantity    <= qty;
    do @(posedge clk); while (!in_ready);
    exp_reports.push_back(book_order(sd, price, qty));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (exp_reports.size() != 0) @(posedge clk);
  endtask

  task automatic random_order();
    bit [31:0] p, q;
    int        sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) p = $urandom;
    else p = band_base + $urandom_range(3900, 4300);
    sel = $urandom_range(0, 99);
    if (sel < 70) q = $urandom_range(1, 100);
    else if (sel < 85) q = $urandom_range(0, 1000);
    else if (sel < 93) q = $urandom_range(200, 3000);
    else q = $urandom;
    send_order(1'($urandom_range(0, 1)), p, q);
  endtask

  task automatic test_directed();
    send_order(0, 100, 10);                  // unplaced band, rests bid
    send_order(1, 0, 0);                     // zero quantity
    send_order(1, 100, 4);
    send_order(1, 0, 5);
    send_order(1, 0, 3);                     // rests an ask at price zero
    send_order(0, 0, 2);                     // book empties
    send_order(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // recentres at the top
    send_order(1, 0, 1);                     // outside band, book not empty
    send_order(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(0, 5, 7);                     // recentres back to zero
    send_order(1, BAND, 1);
    send_order(1, BAND - 1, 3);
    send_order(0, BAND - 1, 10);
    send_order(1, 200, 1);
    send_order(1, 201, 2);
    send_order(1, 201, 3);
    send_order(1, 300, 4);
    send_order(0, 250, 100);                 // no ask at or below 250, rests a bid
    send_order(1, 0, 32'hFFFF_FFFF);         // clears every bid
    send_order(0, BAND - 1, 32'hFFFF_FFFF);  // clears every ask
    send_order(1, 32'h5555_5555, 1);
    send_order(0, 32'hAAAA_AAAA, 32'h5555_5555);
    wait_drained();
  endtask

  task automatic test_random(int n);
    repeat (n) random_order();
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 300;
    repeat (40) send_order(1'($urandom_range(0, 1)), band_base + $urandom_range(4000, 4100),
                           $urandom_range(1, 50), 1);
  endtask

  task automatic test_drain_pause();
    repeat (20) random_order();
    wait_drained();
    repeat (20) random_order();
  endtask

  initial begin
    errors = 0;
    hold_cycles = 0;
    band_base = 0;
    resting_cnt = 0;
    trade_tot = 0;
    volume_tot = 0;
    reject_tot = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    side <= 1'b0;
    limit_price <= '0;
    quantity <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_random(700);
    test_drain_pause();
    test_random(100);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/lobm_pkg.sv
rtl/lobm_ctrl.sv
rtl/lobm_dp.sv
rtl/limit_order_book_matcher_top.sv
rtl/lobm_checker.sv
tb/tb_limit_order_book_matcher_top.sv
